// ----- src/lcst_pkg.sv -----
`default_nettype none
package lcst_pkg;

	localparam int MAX_WIDTH = 64;
	localparam int MAX_HEIGHT = 64;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	// Wide enough for the 7-bit size registers and for the largest frame size.
	localparam int CMP_W = ($clog2(MAX_DIM + 1) > 7) ? $clog2(MAX_DIM + 1) : 7;

	localparam int PIX_W = 24;
	localparam int CH_W = 8;
	localparam int NUM_CH = 3;

	localparam logic [1:0] REG_WIDTH = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_THRESHOLD = 2'd2;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic [1:0] OFS_LAST = 2'd2;
	localparam logic [1:0] OFS_CENTER = 2'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_DONE
	} lcst_state_t;

endpackage
`default_nettype wire

// ----- src/local_contrast_sample_test.sv -----
// Local contrast test over a stored frame of 24-bit RGB pixels.
// Input channel (in_valid / in_stall): func, col, row, pixel_color. A write
// transaction stores pixel_color at (col, row); a query transaction scans the
// in-frame 3x3 neighborhood of (col, row) and reports needs_sample when any
// channel's max minus center, or center minus min, exceeds threshold_level.
// Items outside the frame in use report error and leave the frame untouched.
// Output channel (out_valid / out_stall): needs_sample, error, one result per
// item. Configuration channel (cfg_valid / cfg_ready, always ready): cfg_index
// selects width_in_use, height_in_use or threshold_level; cfg_data is the value.
// A query is accepted, then makes nine reads of the single-port frame memory
// (one per cycle) in ST_SCAN, takes the last read data in ST_LAST and decides
// in ST_DONE, where the result is loaded. Writes and errors go to ST_DONE.
// One item is in work at a time; the next item is accepted once the result of
// the previous one sits in the output register, even while out_stall is high.
// A stalled result holds its value until taken; the block then waits in its
// final state and stalls its input after that.
// Reset clears the control state and sets the registers to 64, 64 and 25;
// the frame memory is not cleared and every pixel must be written before use.
`default_nettype none
module local_contrast_sample_test (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        func,
	input  wire logic [5:0]  col,
	input  wire logic [5:0]  row,
	input  wire logic [23:0] pixel_color,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             needs_sample,
	output logic             error,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);

	localparam int CW = lcst_pkg::CMP_W;
	localparam int AW = lcst_pkg::ADDR_W;
	localparam int PW = lcst_pkg::PIX_W;
	localparam int CHW = lcst_pkg::CH_W;

	function automatic logic [AW-1:0] pix_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
		logic [AW-1:0] a;
		a = AW'(r[lcst_pkg::ROW_W-1:0]) * AW'(lcst_pkg::MAX_WIDTH)
			+ AW'(c[lcst_pkg::COL_W-1:0]);
		return a;
	endfunction

	// Configuration registers.
	logic [6:0] width_q;
	logic [6:0] height_q;
	logic [7:0] thresh_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 7'd64;
			height_q <= 7'd64;
			thresh_q <= 8'd25;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lcst_pkg::REG_WIDTH: width_q <= cfg_data[6:0];
				lcst_pkg::REG_HEIGHT: height_q <= cfg_data[6:0];
				lcst_pkg::REG_THRESHOLD: thresh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	lcst_pkg::lcst_state_t state_q, state_d;

	logic          out_free;
	logic          in_acc;
	logic          in_frame;
	logic [CW-1:0] col_ext, row_ext, w_ext, h_ext;
	logic [CW-1:0] col_q, row_q;
	logic          query_q;
	logic          err_q;
	logic [1:0]    dc_q, dr_q;
	logic [CW-1:0] nc, nr;
	logic          nb_in;
	logic          scan_end;
	logic          load_out;
	logic          need_d;

	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [PW-1:0] mem [lcst_pkg::DEPTH];
	logic [PW-1:0] rdata_s1;
	logic          rd_valid_s1;
	logic          rd_center_s1;

	logic [PW-1:0] hi_q, lo_q, center_q;

	assign out_free = !out_valid || !out_stall;
	assign in_acc = in_valid && !in_stall;

	assign col_ext = CW'(col);
	assign row_ext = CW'(row);
	assign w_ext = CW'(width_q);
	assign h_ext = CW'(height_q);
	assign in_frame = (col_ext < w_ext) && (col_ext < CW'(lcst_pkg::MAX_WIDTH))
		&& (row_ext < h_ext) && (row_ext < CW'(lcst_pkg::MAX_HEIGHT));

	// Neighbor coordinates; a step left of column 0 wraps to all ones and so
	// falls outside the frame on its own.
	assign nc = col_q + CW'(dc_q) - CW'(1);
	assign nr = row_q + CW'(dr_q) - CW'(1);
	assign nb_in = (nc < w_ext) && (nc < CW'(lcst_pkg::MAX_WIDTH))
		&& (nr < h_ext) && (nr < CW'(lcst_pkg::MAX_HEIGHT));
	assign scan_end = (dc_q == lcst_pkg::OFS_LAST) && (dr_q == lcst_pkg::OFS_LAST);

	// Frame memory, single port: writes only in the accepting cycle of a write.
	assign mem_we = in_acc && in_frame && (func == lcst_pkg::FUNC_WRITE);
	assign mem_addr = (state_q == lcst_pkg::ST_IDLE) ? pix_addr(row_ext, col_ext)
		: pix_addr(nr, nc);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= pixel_color;
		end
		rdata_s1 <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcst_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_stall = 1'b1;
		load_out = 1'b0;
		case (state_q)
			lcst_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (in_frame && (func == lcst_pkg::FUNC_QUERY)) begin
						state_d = lcst_pkg::ST_SCAN;
					end else begin
						state_d = lcst_pkg::ST_DONE;
					end
				end
			end
			lcst_pkg::ST_SCAN: begin
				if (scan_end) begin
					state_d = lcst_pkg::ST_LAST;
				end
			end
			lcst_pkg::ST_LAST: begin
				state_d = lcst_pkg::ST_DONE;
			end
			lcst_pkg::ST_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d = lcst_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lcst_pkg::ST_IDLE;
			end
		endcase
	end

	// Item registers and the neighbor scan counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_q <= '0;
			dr_q <= '0;
			rd_valid_s1 <= 1'b0;
			rd_center_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == lcst_pkg::ST_SCAN) && nb_in;
			rd_center_s1 <= (state_q == lcst_pkg::ST_SCAN)
				&& (dc_q == lcst_pkg::OFS_CENTER) && (dr_q == lcst_pkg::OFS_CENTER);
			if (in_acc) begin
				dc_q <= '0;
				dr_q <= '0;
			end else if (state_q == lcst_pkg::ST_SCAN) begin
				if (dr_q == lcst_pkg::OFS_LAST) begin
					dr_q <= '0;
					dc_q <= dc_q + 2'd1;
				end else begin
					dr_q <= dr_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			col_q <= col_ext;
			row_q <= row_ext;
			query_q <= in_frame && (func == lcst_pkg::FUNC_QUERY);
			err_q <= !in_frame;
			hi_q <= '0;
			lo_q <= '1;
		end else if (rd_valid_s1) begin
			for (int k = 0; k < lcst_pkg::NUM_CH; k++) begin
				if (rdata_s1[k*CHW +: CHW] > hi_q[k*CHW +: CHW]) begin
					hi_q[k*CHW +: CHW] <= rdata_s1[k*CHW +: CHW];
				end
				if (rdata_s1[k*CHW +: CHW] < lo_q[k*CHW +: CHW]) begin
					lo_q[k*CHW +: CHW] <= rdata_s1[k*CHW +: CHW];
				end
			end
		end
		if (rd_center_s1) begin
			center_q <= rdata_s1;
		end
	end

	always_comb begin
		need_d = 1'b0;
		for (int k = 0; k < lcst_pkg::NUM_CH; k++) begin
			if ((hi_q[k*CHW +: CHW] - center_q[k*CHW +: CHW]) > thresh_q) begin
				need_d = 1'b1;
			end
			if ((center_q[k*CHW +: CHW] - lo_q[k*CHW +: CHW]) > thresh_q) begin
				need_d = 1'b1;
			end
		end
		need_d = need_d && query_q;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			needs_sample <= need_d;
			error <= err_q;
		end
	end

	a_err_no_need: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(error && needs_sample))
		else $error("error and needs_sample both set");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == lcst_pkg::ST_IDLE))
		else $error("frame memory written outside an accepted write");

	a_read_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> ($past(state_q) == lcst_pkg::ST_SCAN))
		else $error("neighbor data taken without a scan read");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lcst_pkg::ST_DONE) && out_free |=> out_valid)
		else $error("finished item not loaded into the output register");

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lcst_pkg::ST_SCAN) || (state_q == lcst_pkg::ST_LAST) |-> in_stall)
		else $error("input accepted during a neighborhood scan");

endmodule
`default_nettype wire

// ----- dv/local_contrast_sample_test_tb.sv -----
`default_nettype none
module local_contrast_sample_test_tb;

	localparam int QUIET_LIMIT = 2000;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 125;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic need;
		logic err;
	} verdict_t;

	typedef struct packed {
		bit   on;
		logic need;
		logic err;
	} typed_t;

	typedef struct packed {
		bit          is_cfg;
		logic [1:0]  idx;
		logic [7:0]  data;
		logic        fn;
		logic [5:0]  c;
		logic [5:0]  r;
		logic [23:0] color;
		bit          on;
		logic        need;
		logic        err;
	} plan_row_t;

	// Directed part: extremes, the threshold boundary, edges of the frame,
	// dropped writes, a zero-size frame, a center-only frame and oversized sizes.
	localparam plan_row_t PLAN [32] = '{
		'{1'b0, lcst_pkg::REG_WIDTH, 8'h00, lcst_pkg::FUNC_WRITE,
			6'd0, 6'd0, 24'h000000, 1'b1, 1'b0, 1'b0},
		'{1'b0, lcst_pkg::REG_WIDTH, 8'h00, lcst_pkg::FUNC_WRITE,
			6'd63, 6'd63, 24'hFFFFFF, 1'b1, 1'b0, 1'b0},
		'{1'b0, lcst_pkg::REG_WIDTH, 8'h00, lcst_pkg::FUNC_WRITE,
			6'd62, 6'd63, 24'hFFFFFF, 1'b1, 1'b0, 1'b0},
		'{1'b0, lcst_pkg::REG_WIDTH, 8'h00, lcst_pkg::FUNC_WRITE,
			6'd63, 6'd62, 24'hFFFFFF, 1'b1, 1'b0, 1'b0},
		'{1'b0, lcst_pkg::REG_WIDTH, 8'h00, lcst_pkg::FUNC_WRITE,
			6'd62, 6'd62, 24'hFFFFFF, 1'b1, 1'b0, 1'b0},
		'{1'b0, lcst_pkg::REG_WIDTH, 8'h00, lcst_pkg::FUNC_QUERY,
			6'd63, 6'd63, 24'h000000, 1'b1, 1'b0, 1'b0},
		'{1'b0, lcst_pkg::REG_WIDTH, 8'h00, lcst_pkg::FUNC_WRITE,
			6'd1, 6'd0, 24'h000000, 1'b1, 1'b0, 1'b0},
		'{1'b0, lcst_pkg::REG_WIDTH, 8'h00, lcst_pkg::FUNC_WRITE,
			6'd0, 6'd1, 24'h000000, 1'b1, 1'b0, 1'b0},
		'{1'b0, lcst_pkg::REG_WIDTH, 8'h00, lcst_pkg::FUNC_WRITE,
			6'd1, 6'd1, 24'h1A0000, 1'b1, 1'b0, 1'b0},
		'{1'b0, lcst_pkg::REG_WIDTH, 8'h00, lcst_pkg::FUNC_QUERY,
			6'd0, 6'd0, 24'h000000, 1'b1, 1'b1, 1'b0},
		'{1'b0, lcst_pkg::REG_WIDTH, 8'h00, lcst_pkg::FUNC_WRITE,
			6'd1, 6'd1, 24'h190000, 1'b1, 1'b0, 1'b0},
		'{1'b0, lcst_pkg::REG_WIDTH, 8'h00, lcst_pkg::FUNC_QUERY,
			6'd0, 6'd0, 24'h000000, 1'b1, 1'b0, 1'b0},
		'{1'b1, lcst_pkg::REG_THRESHOLD, 8'd0, lcst_pkg::FUNC_WRITE,
			6'd0, 6'd0, 24'h0, 1'b0, 1'b0, 1'b0},
		'{1'b0, lcst_pkg::REG_WIDTH, 8'h00, lcst_pkg::FUNC_QUERY,
			6'd0, 6'd0, 24'h000000, 1'b1, 1'b1, 1'b0},
		'{1'b1, lcst_pkg::REG_THRESHOLD, 8'd255, lcst_pkg::FUNC_WRITE,
			6'd0, 6'd0, 24'h0, 1'b0, 1'b0, 1'b0},
		'{1'b0, lcst_pkg::REG_WIDTH, 8'h00, lcst_pkg::FUNC_WRITE,
			6'd1, 6'd0, 24'hFFFFFF, 1'b1, 1'b0, 1'b0},
		'{1'b0, lcst_pkg::REG_WIDTH, 8'h00, lcst_pkg::FUNC_QUERY,
			6'd0, 6'd0, 24'h000000, 1'b1, 1'b0, 1'b0},
		'{1'b1, lcst_pkg::REG_WIDTH, 8'd2, lcst_pkg::FUNC_WRITE,
			6'd0, 6'd0, 24'h0, 1'b0, 1'b0, 1'b0},
		'{1'b1, lcst_pkg::REG_HEIGHT, 8'd2, lcst_pkg::FUNC_WRITE,
			6'd0, 6'd0, 24'h0, 1'b0, 1'b0, 1'b0},
		'{1'b1, lcst_pkg::REG_THRESHOLD, 8'd25, lcst_pkg::FUNC_WRITE,
			6'd0, 6'd0, 24'h0, 1'b0, 1'b0, 1'b0},
		'{1'b0, lcst_pkg::REG_WIDTH, 8'h00, lcst_pkg::FUNC_WRITE,
			6'd2, 6'd0, 24'h55AA55, 1'b1, 1'b0, 1'b1},
		'{1'b0, lcst_pkg::REG_WIDTH, 8'h00, lcst_pkg::FUNC_QUERY,
			6'd0, 6'd2, 24'h000000, 1'b1, 1'b0, 1'b1},
		'{1'b0, lcst_pkg::REG_WIDTH, 8'h00, lcst_pkg::FUNC_WRITE,
			6'd63, 6'd63, 24'h123456, 1'b1, 1'b0, 1'b1},
		'{1'b1, lcst_pkg::REG_WIDTH, 8'd0, lcst_pkg::FUNC_WRITE,
			6'd0, 6'd0, 24'h0, 1'b0, 1'b0, 1'b0},
		'{1'b0, lcst_pkg::REG_WIDTH, 8'h00, lcst_pkg::FUNC_QUERY,
			6'd0, 6'd0, 24'h000000, 1'b1, 1'b0, 1'b1},
		'{1'b0, lcst_pkg::REG_WIDTH, 8'h00, lcst_pkg::FUNC_WRITE,
			6'd0, 6'd0, 24'hAAAAAA, 1'b1, 1'b0, 1'b1},
		'{1'b1, lcst_pkg::REG_WIDTH, 8'd1, lcst_pkg::FUNC_WRITE,
			6'd0, 6'd0, 24'h0, 1'b0, 1'b0, 1'b0},
		'{1'b1, lcst_pkg::REG_HEIGHT, 8'd1, lcst_pkg::FUNC_WRITE,
			6'd0, 6'd0, 24'h0, 1'b0, 1'b0, 1'b0},
		'{1'b0, lcst_pkg::REG_WIDTH, 8'h00, lcst_pkg::FUNC_QUERY,
			6'd0, 6'd0, 24'h000000, 1'b1, 1'b0, 1'b0},
		'{1'b1, lcst_pkg::REG_WIDTH, 8'hFF, lcst_pkg::FUNC_WRITE,
			6'd0, 6'd0, 24'h0, 1'b0, 1'b0, 1'b0},
		'{1'b1, lcst_pkg::REG_HEIGHT, 8'hC0, lcst_pkg::FUNC_WRITE,
			6'd0, 6'd0, 24'h0, 1'b0, 1'b0, 1'b0},
		'{1'b0, lcst_pkg::REG_WIDTH, 8'h00, lcst_pkg::FUNC_QUERY,
			6'd63, 6'd63, 24'h000000, 1'b1, 1'b0, 1'b0}
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        func;
	logic [5:0]  col;
	logic [5:0]  row;
	logic [23:0] pixel_color;
	logic        out_valid;
	logic        out_stall;
	logic        needs_sample;
	logic        error;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;

	local_contrast_sample_test dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.col          (col),
		.row          (row),
		.pixel_color  (pixel_color),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.needs_sample (needs_sample),
		.error        (error),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Predictor state: frame contents and the registers as last written.
	logic [23:0] frame_mem [lcst_pkg::DEPTH];
	logic [6:0]  frame_w = 7'd64;
	logic [6:0]  frame_h = 7'd64;
	logic [7:0]  thr_level = 8'd25;

	// Pixels the stimulus has written, so that no query reads a stale entry.
	bit          filled [lcst_pkg::DEPTH];

	verdict_t    verdict_q [$];
	typed_t      typed_q [$];
	verdict_t    want;
	verdict_t    seen;
	typed_t      fixed;
	int          fails = 0;
	int          quiet = 0;
	int          items_sent = 0;

	logic [23:0] tone = 24'h808080;
	int          spread = 8;
	bit          calm = 1'b0;
	bit          hold_req = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int eff_dim(logic [6:0] v, int cap);
		return (int'(v) > cap) ? cap : int'(v);
	endfunction

	function automatic void contrast_predict(input logic fn, input logic [5:0] c,
		input logic [5:0] r, input logic [23:0] color, output verdict_t v);
		int w;
		int h;
		int nc;
		int nr;
		int k;
		int mid;
		int hi [3];
		int lo [3];
		logic [23:0] pix;
		logic [23:0] centre;
		w = eff_dim(frame_w, lcst_pkg::MAX_WIDTH);
		h = eff_dim(frame_h, lcst_pkg::MAX_HEIGHT);
		v = '0;
		if (int'(c) >= w || int'(r) >= h) begin
			v.err = 1'b1;
		end else if (fn == lcst_pkg::FUNC_WRITE) begin
			frame_mem[int'(r) * lcst_pkg::MAX_WIDTH + int'(c)] = color;
		end else begin
			for (k = 0; k < lcst_pkg::NUM_CH; k++) begin
				hi[k] = 0;
				lo[k] = 255;
			end
			centre = frame_mem[int'(r) * lcst_pkg::MAX_WIDTH + int'(c)];
			for (int dr = -1; dr <= 1; dr++) begin
				for (int dc = -1; dc <= 1; dc++) begin
					nc = int'(c) + dc;
					nr = int'(r) + dr;
					if (nc >= 0 && nr >= 0 && nc < w && nr < h) begin
						pix = frame_mem[nr * lcst_pkg::MAX_WIDTH + nc];
						for (k = 0; k < lcst_pkg::NUM_CH; k++) begin
							if (int'(pix[8*k +: 8]) > hi[k])
								hi[k] = int'(pix[8*k +: 8]);
							if (int'(pix[8*k +: 8]) < lo[k])
								lo[k] = int'(pix[8*k +: 8]);
						end
					end
				end
			end
			for (k = 0; k < lcst_pkg::NUM_CH; k++) begin
				mid = int'(centre[8*k +: 8]);
				if (hi[k] - mid > int'(thr_level) || mid - lo[k] > int'(thr_level))
					v.need = 1'b1;
			end
		end
	endfunction

	// Colors cluster around a per-phase tone so that both answers are common.
	function automatic logic [23:0] make_color();
		int sel;
		int ch;
		logic [23:0] pcol;
		sel = $urandom_range(0, 99);
		if (sel < 15)
			return tone;
		if (sel < 27)
			return 24'($urandom());
		if (sel < 31)
			return ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h000000;
		for (int k = 0; k < lcst_pkg::NUM_CH; k++) begin
			ch = int'(tone[8*k +: 8]) + int'($urandom_range(0, 2 * spread)) - spread;
			if (ch < 0)
				ch = 0;
			if (ch > 255)
				ch = 255;
			pcol[8*k +: 8] = ch[7:0];
		end
		return pcol;
	endfunction

	task automatic send_item(input logic fn, input logic [5:0] c, input logic [5:0] r,
		input logic [23:0] color, input typed_t typed);
		@(negedge clk);
		while (!calm && ($urandom_range(0, 99) < 16)) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		if (fn == lcst_pkg::FUNC_WRITE
				&& int'(c) < eff_dim(frame_w, lcst_pkg::MAX_WIDTH)
				&& int'(r) < eff_dim(frame_h, lcst_pkg::MAX_HEIGHT))
			filled[int'(r) * lcst_pkg::MAX_WIDTH + int'(c)] = 1'b1;
		typed_q.push_back(typed);
		in_valid <= 1'b1;
		func <= fn;
		col <= c;
		row <= r;
		pixel_color <= color;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// Writes every in-frame neighbor of (c, r) that has not been written yet.
	task automatic fill_hood(input logic [5:0] c, input logic [5:0] r);
		int w;
		int h;
		int nc;
		int nr;
		w = eff_dim(frame_w, lcst_pkg::MAX_WIDTH);
		h = eff_dim(frame_h, lcst_pkg::MAX_HEIGHT);
		if (int'(c) < w && int'(r) < h) begin
			for (int dr = -1; dr <= 1; dr++) begin
				for (int dc = -1; dc <= 1; dc++) begin
					nc = int'(c) + dc;
					nr = int'(r) + dr;
					if (nc >= 0 && nr >= 0 && nc < w && nr < h
							&& !filled[nr * lcst_pkg::MAX_WIDTH + nc])
						send_item(lcst_pkg::FUNC_WRITE, 6'(nc), 6'(nr), make_color(), '0);
				end
			end
		end
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick_dim();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd64;
			3: return 8'($urandom_range(65, 255));
			4: return 8'd2;
			default: return 8'($urandom_range(3, 12));
		endcase
	endfunction

	function automatic logic [7:0] pick_threshold();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd25;
			5: return 8'($urandom_range(0, 255));
			default: return 8'($urandom_range(0, 40));
		endcase
	endfunction

	// Receiver side: random stalls, plus one long hold-off on request.
	initial begin
		int hold_cnt;
		hold_cnt = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cnt > 0) begin
				out_stall <= 1'b1;
				hold_cnt--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_cnt = HOLD_CYCLES;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(0, 99) < 16);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				seen.need = needs_sample;
				seen.err = error;
				if (verdict_q.size() == 0) begin
					$display("%0t: unexpected result needs_sample=%0b error=%0b",
						$time, needs_sample, error);
					fails++;
				end else begin
					want = verdict_q.pop_front();
					fixed = typed_q.pop_front();
					if (seen.need !== want.need) begin
						$display("%0t: needs_sample expected %0b actual %0b",
							$time, want.need, seen.need);
						fails++;
					end
					if (seen.err !== want.err) begin
						$display("%0t: error expected %0b actual %0b",
							$time, want.err, seen.err);
						fails++;
					end
					if (fixed.on && (seen.need !== fixed.need || seen.err !== fixed.err)) begin
						$display("%0t: directed result expected %0b/%0b actual %0b/%0b",
							$time, fixed.need, fixed.err, seen.need, seen.err);
						fails++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				contrast_predict(func, col, row, pixel_color, want);
				verdict_q.push_back(want);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					lcst_pkg::REG_WIDTH: frame_w = cfg_data[6:0];
					lcst_pkg::REG_HEIGHT: frame_h = cfg_data[6:0];
					lcst_pkg::REG_THRESHOLD: thr_level = cfg_data;
					default: ;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)
					|| (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		int base;
		int sel;
		int w;
		int h;
		logic fn;
		logic [5:0] c;
		logic [5:0] r;
		logic [7:0] wd;
		logic [7:0] hd;
		logic [7:0] td;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = lcst_pkg::FUNC_WRITE;
		col = '0;
		row = '0;
		pixel_color = '0;
		cfg_valid = 1'b0;
		cfg_index = lcst_pkg::REG_WIDTH;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (PLAN[i]) begin
			if (PLAN[i].is_cfg) begin
				settle();
				write_reg(PLAN[i].idx, PLAN[i].data);
			end else begin
				send_item(PLAN[i].fn, PLAN[i].c, PLAN[i].r, PLAN[i].color,
					'{PLAN[i].on, PLAN[i].need, PLAN[i].err});
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin wd = 8'd64; hd = 8'd64; td = 8'd0; end
				1: begin wd = 8'd3; hd = 8'd3; td = 8'd25; end
				2: begin wd = 8'hFF; hd = 8'hC0; td = 8'd255; end
				3: begin wd = 8'd1; hd = 8'd64; td = 8'd25; end
				4: begin wd = 8'd12; hd = 8'd5; td = pick_threshold(); end
				default: begin wd = pick_dim(); hd = pick_dim(); td = pick_threshold(); end
			endcase
			settle();
			write_reg(lcst_pkg::REG_WIDTH, wd);
			write_reg(lcst_pkg::REG_HEIGHT, hd);
			write_reg(lcst_pkg::REG_THRESHOLD, td);
			tone = 24'($urandom());
			spread = $urandom_range(0, 40);
			calm = (ph == 2);
			// The receiver holds off while items keep coming, filling the block.
			if (ph == 4)
				hold_req = 1'b1;
			base = items_sent;
			while (items_sent - base < PHASE_ITEMS) begin
				w = eff_dim(frame_w, lcst_pkg::MAX_WIDTH);
				h = eff_dim(frame_h, lcst_pkg::MAX_HEIGHT);
				sel = $urandom_range(0, 99);
				if (w == 0 || h == 0 || $urandom_range(0, 99) < 15) begin
					c = 6'($urandom_range(0, 63));
					r = 6'($urandom_range(0, 63));
				end else begin
					c = 6'($urandom_range(0, w - 1));
					r = 6'($urandom_range(0, h - 1));
				end
				if (sel < 40) begin
					send_item(lcst_pkg::FUNC_WRITE, c, r, make_color(), '0);
				end else if (sel < 90) begin
					fill_hood(c, r);
					send_item(lcst_pkg::FUNC_QUERY, c, r, 24'($urandom()), '0);
				end else begin
					fn = 1'($urandom_range(0, 1));
					c = 6'($urandom_range(0, 63));
					r = 6'($urandom_range(0, 63));
					if (fn == lcst_pkg::FUNC_QUERY)
						fill_hood(c, r);
					send_item(fn, c, r, 24'($urandom()), '0);
				end
			end
		end

		calm = 1'b0;
		@(negedge clk);
		in_valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (fails == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire
